FILE: rtl/gcsp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// gcsp_pkg - shared types and constants of the glyph cache shelf packer
// Sequencer states, result status codes, register indexes and reset values.
// ----------------------------------------------------------------------------
package gcsp_pkg;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_MISS,
		ST_FIT_X,
		ST_WRAP,
		ST_FIT_Y,
		ST_ADV
	} state_t;

	typedef enum logic [2:0] {
		STS_HIT        = 3'd0,
		STS_INSERTED   = 3'd1,
		STS_TABLE_FULL = 3'd2,
		STS_ATLAS_FULL = 3'd3,
		STS_RESET_DONE = 3'd4
	} status_t;

	localparam logic       CFG_ATLAS_SIZE = 1'b0;
	localparam logic       CFG_PAD_PIXELS = 1'b1;

	localparam logic       MODE_LOOKUP = 1'b0;
	localparam logic       MODE_RESET  = 1'b1;

	localparam logic [12:0] ATLAS_SIZE_RST = 13'd1024;
	localparam logic [3:0]  PAD_PIXELS_RST = 4'd2;
	localparam logic [13:0] PEN_Y_MAX      = 14'd16383;

endpackage

`default_nettype wire

FILE: rtl/glyph_cache_shelf_packer_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// glyph_cache_shelf_packer_core - glyph table with shelf packing atlas
// Looks up a code point in the glyph table, or places a new glyph in the
// atlas at the pen with shelf wrap, or empties the table on a reset request.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. A reset request
// answers in the cycle after it is taken and leaves busy low. A lookup reads
// the glyph table one entry per cycle from its single read port; an entry is
// compared with the code point from its registered read, and a hit answers
// through the result register. A miss over the stored entries moves to
// ST_MISS, from which a full table or a zero-size glyph answers, and a glyph
// to pack takes two to four steps of the shared packing adder (width fit,
// shelf wrap, height fit, pen advance). The longest request packs a glyph
// with a shelf wrap over 511 stored entries; a full table of 512 entries
// answers sooner. The result is presented for one cycle with done high and
// must be captured then; it cannot be held off.
// ----------------------------------------------------------------------------
module glyph_cache_shelf_packer_core
	import gcsp_pkg::*;
#(
	parameter int TABLE_DEPTH = 512
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        mode,
	input  wire logic [20:0] code_point,
	input  wire logic [11:0] bitmap_width,
	input  wire logic [11:0] bitmap_height,
	input  wire logic        cfg_we,
	input  wire logic        cfg_addr,
	input  wire logic [12:0] cfg_wdata,
	output logic             done,
	output logic [2:0]       status,
	output logic [11:0]      place_x,
	output logic [11:0]      place_y,
	output logic [11:0]      size_w,
	output logic [11:0]      size_h,
	output logic [8:0]       slot
);

	localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
	localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

	// glyph table
	logic [20:0] mem_code  [TABLE_DEPTH];
	logic [23:0] mem_place [TABLE_DEPTH];
	logic [23:0] mem_size  [TABLE_DEPTH];

	state_t      state_q, state_d;
	logic [12:0] atlas_q;
	logic [3:0]  pad_q;
	logic [CNT_W-1:0] total_q;
	logic [12:0] pen_x_q;
	logic [13:0] pen_y_q;
	logic [11:0] shelf_q;
	logic [CNT_W-1:0] scan_q;

	logic [20:0] code_q;
	logic [11:0] w_q, h_q;

	logic             cmp_vld_s1;
	logic [IDX_W-1:0] cmp_idx_s1;
	logic [20:0]      rd_code_s1;
	logic [23:0]      rd_place_s1;
	logic [23:0]      rd_size_s1;

	logic        done_q;
	status_t     status_q;
	logic [11:0] px_q, py_q, sw_q, sh_q;
	logic [8:0]  slot_q;

	logic        accept, issue, hit, tbl_full, zero_size, over;
	logic [13:0] add_a;
	logic [11:0] add_b;
	logic [14:0] sum;
	logic [13:0] pen_y_wrap;
	logic [IDX_W-1:0] wr_idx;

	logic        out_load, wr_en, inc_total;
	status_t     out_sts;
	logic [11:0] out_px, out_py, out_w, out_h;
	logic [8:0]  out_slot;

	assign accept    = start && !busy;
	assign busy      = (state_q != ST_IDLE);
	assign issue     = (scan_q < total_q);
	assign hit       = cmp_vld_s1 && (rd_code_s1 == code_q);
	assign tbl_full  = (total_q >= CNT_W'(TABLE_DEPTH));
	assign zero_size = (w_q == 12'd0) || (h_q == 12'd0);
	assign wr_idx    = total_q[IDX_W-1:0];

	// shared packing adder
	always_comb begin
		case (state_q)
			ST_WRAP: begin
				add_a = pen_y_q;
				add_b = shelf_q;
			end
			ST_FIT_Y: begin
				add_a = pen_y_q;
				add_b = h_q;
			end
			default: begin
				add_a = {1'b0, pen_x_q};
				add_b = w_q;
			end
		endcase
	end

	assign sum        = {1'b0, add_a} + {3'b000, add_b} + {11'd0, pad_q};
	assign over       = (sum > {2'b00, atlas_q});
	assign pen_y_wrap = (sum > {1'b0, PEN_Y_MAX}) ? PEN_Y_MAX : sum[13:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		out_load  = 1'b0;
		wr_en     = 1'b0;
		inc_total = 1'b0;
		out_sts   = STS_INSERTED;
		out_px    = 12'd0;
		out_py    = 12'd0;
		out_w     = w_q;
		out_h     = h_q;
		out_slot  = 9'(total_q);
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (mode == MODE_RESET) begin
						out_load = 1'b1;
						out_sts  = STS_RESET_DONE;
						out_w    = 12'd0;
						out_h    = 12'd0;
						out_slot = 9'd0;
					end else begin
						state_d = ST_SCAN;
					end
				end
			end
			ST_SCAN: begin
				if (hit) begin
					out_load = 1'b1;
					out_sts  = STS_HIT;
					out_px   = rd_place_s1[11:0];
					out_py   = rd_place_s1[23:12];
					out_w    = rd_size_s1[11:0];
					out_h    = rd_size_s1[23:12];
					out_slot = 9'(cmp_idx_s1);
					state_d  = ST_IDLE;
				end else if (!issue && !cmp_vld_s1) begin
					state_d = ST_MISS;
				end
			end
			ST_MISS: begin
				if (tbl_full) begin
					out_load = 1'b1;
					out_sts  = STS_TABLE_FULL;
					out_slot = 9'd0;
					state_d  = ST_IDLE;
				end else if (zero_size) begin
					out_load  = 1'b1;
					wr_en     = 1'b1;
					inc_total = 1'b1;
					state_d   = ST_IDLE;
				end else begin
					state_d = ST_FIT_X;
				end
			end
			ST_FIT_X: begin
				state_d = over ? ST_WRAP : ST_FIT_Y;
			end
			ST_WRAP: begin
				state_d = ST_FIT_Y;
			end
			ST_FIT_Y: begin
				if (over) begin
					out_load = 1'b1;
					out_sts  = STS_ATLAS_FULL;
					out_slot = 9'd0;
					state_d  = ST_IDLE;
				end else begin
					state_d = ST_ADV;
				end
			end
			ST_ADV: begin
				out_load  = 1'b1;
				wr_en     = 1'b1;
				inc_total = 1'b1;
				out_px    = pen_x_q[11:0];
				out_py    = pen_y_q[11:0];
				state_d   = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			atlas_q    <= ATLAS_SIZE_RST;
			pad_q      <= PAD_PIXELS_RST;
			total_q    <= '0;
			pen_x_q    <= 13'(PAD_PIXELS_RST);
			pen_y_q    <= 14'(PAD_PIXELS_RST);
			shelf_q    <= 12'd0;
			scan_q     <= '0;
			cmp_vld_s1 <= 1'b0;
			done_q     <= 1'b0;
		end else begin
			done_q     <= out_load;
			cmp_vld_s1 <= (state_q == ST_SCAN) && issue && !hit;
			if (cfg_we) begin
				if (cfg_addr == CFG_ATLAS_SIZE) begin
					atlas_q <= cfg_wdata;
				end else begin
					pad_q <= cfg_wdata[3:0];
				end
			end
			if (inc_total) begin
				total_q <= total_q + CNT_W'(1);
			end
			case (state_q)
				ST_IDLE: begin
					scan_q <= '0;
					if (accept && mode == MODE_RESET) begin
						total_q <= '0;
						pen_x_q <= 13'(pad_q);
						pen_y_q <= 14'(pad_q);
						shelf_q <= 12'd0;
					end
				end
				ST_SCAN: begin
					if (issue) begin
						scan_q <= scan_q + CNT_W'(1);
					end
				end
				ST_FIT_X: begin
					if (over) begin
						pen_x_q <= 13'(pad_q);
					end
				end
				ST_WRAP: begin
					pen_y_q <= pen_y_wrap;
					shelf_q <= 12'd0;
				end
				ST_ADV: begin
					pen_x_q <= sum[12:0];
					if (h_q > shelf_q) begin
						shelf_q <= h_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// request capture, table read and write, result register
	always_ff @(posedge clk) begin
		if (accept) begin
			code_q <= code_point;
			w_q    <= bitmap_width;
			h_q    <= bitmap_height;
		end
		rd_code_s1  <= mem_code[scan_q[IDX_W-1:0]];
		rd_place_s1 <= mem_place[scan_q[IDX_W-1:0]];
		rd_size_s1  <= mem_size[scan_q[IDX_W-1:0]];
		cmp_idx_s1  <= scan_q[IDX_W-1:0];
		if (wr_en) begin
			mem_code[wr_idx]  <= code_q;
			mem_place[wr_idx] <= {out_py, out_px};
			mem_size[wr_idx]  <= {h_q, w_q};
		end
		if (out_load) begin
			status_q <= out_sts;
			px_q     <= out_px;
			py_q     <= out_py;
			sw_q     <= out_w;
			sh_q     <= out_h;
			slot_q   <= out_slot;
		end
	end

	assign done    = done_q;
	assign status  = status_q;
	assign place_x = px_q;
	assign place_y = py_q;
	assign size_w  = sw_q;
	assign size_h  = sh_q;
	assign slot    = slot_q;

	a_done_cause: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy || start))
		else $error("result strobe without a request");

	a_total_bound: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CNT_W'(TABLE_DEPTH))
		else $error("glyph count beyond table depth");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (scan_q <= total_q))
		else $error("scan pointer past stored entries");

	a_lookup_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && mode == MODE_LOOKUP) |=> busy && !done)
		else $error("lookup request did not start the scan");

	a_hit_slot: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN && hit) |-> (CNT_W'(cmp_idx_s1) < total_q))
		else $error("hit on an entry that is not stored");

endmodule

`default_nettype wire
